### sv/integer_to_radix_digits_macros.svh
// assertion macros for the radix digit converter
`ifndef INTEGER_TO_RADIX_DIGITS_MACROS_SVH
`define INTEGER_TO_RADIX_DIGITS_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition in this cycle implies a consequence in the same cycle
`define I2RD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// condition in this cycle implies a consequence in the next cycle
`define I2RD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I2RD_ASSERT_NOW(label, clk, rst, ante, cons)
`define I2RD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/i2rd_pkg.sv
package i2rd_pkg;

  localparam logic [4:0] RADIX_RESET = 5'd10;
  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [6:0] ASCII_ZERO  = 7'd48;
  localparam logic [6:0] ASCII_UPPER_A = 7'd65;
  localparam logic [3:0] DECIMAL_TEN = 4'd10;
  localparam logic [0:0] REG_RADIX   = 1'b0;

  // clamp the programmed base into 2..16
  function automatic logic [4:0] sat_radix(input logic [4:0] r);
    logic [4:0] b;
    b = r;
    if (r < RADIX_MIN) b = RADIX_MIN;
    if (r > RADIX_MAX) b = RADIX_MAX;
    return b;
  endfunction

  // highest quotient bit a digit can have in this base
  function automatic logic [1:0] top_bit(input logic [4:0] b);
    logic [1:0] t;
    if (b <= 5'd2) t = 2'd0;
    else if (b <= 5'd4) t = 2'd1;
    else if (b <= 5'd8) t = 2'd2;
    else t = 2'd3;
    return t;
  endfunction

  // digit value to ascii character
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] c;
    if (d < DECIMAL_TEN) c = ASCII_ZERO + {3'b000, d};
    else c = ASCII_UPPER_A + {3'b000, d - DECIMAL_TEN};
    return c;
  endfunction

endpackage

### sv/i2rd_ram.sv
module i2rd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/integer_to_radix_digits.sv
// sequence: accept, a power search that multiplies by the base and stores each power,
// then b compare-subtract steps, where b = 1..4 quotient bits for bases 2, 3-4, 5-8, 9-16, then emit
// each further digit: one ram read, b compare-subtract steps, emit
// a new value is accepted only once the last digit of the previous one is emitted; emit waits on out_ready
// reset (synchronous, active high) sets radix to 10 and idles the sequencer
`include "integer_to_radix_digits_macros.svh"

module integer_to_radix_digits #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // apb configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // input word
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value,
  // output word
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            digit_char,
  output logic                  last_digit
);

  import i2rd_pkg::*;

  localparam int ADDR_W  = $clog2(VALUE_BITS);
  localparam int PROD_W  = VALUE_BITS + 5;
  localparam int TRIAL_W = VALUE_BITS + 4;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ASCEND = 3'd1;
  localparam logic [2:0] ST_DIGIT  = 3'd2;
  localparam logic [2:0] ST_EMIT   = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;

  logic [2:0]            state;
  logic [4:0]            radix;
  logic [4:0]            base;
  logic [VALUE_BITS-1:0] rest;
  logic [VALUE_BITS-1:0] power;
  logic [ADDR_W-1:0]     exp;
  logic [3:0]            d;
  logic [1:0]            s;

  logic [PROD_W-1:0]     prod;
  logic                  asc_ok;
  logic [TRIAL_W-1:0]    trial;
  logic                  fit;
  logic                  emit_go;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr && (paddr[2] == REG_RADIX)) begin
      radix <= pwdata[4:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_RADIX) prdata = {27'd0, radix};
  end

  // shared datapath: power times base, and shifted power against the remainder
  assign prod   = PROD_W'(power) * PROD_W'(base);
  assign asc_ok = prod <= PROD_W'(rest);
  assign trial  = TRIAL_W'(power) << s;
  assign fit    = trial <= TRIAL_W'(rest);

  assign in_ready = (state == ST_IDLE) && !rst;
  assign emit_go  = !out_valid || out_ready;

  // power stack, filled on the way up and read back on the way down
  assign ram_we    = (state == ST_ASCEND);
  assign ram_re    = (state == ST_EMIT) && emit_go && (exp != '0);
  assign ram_raddr = exp - ADDR_W'(1);

  i2rd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VALUE_BITS)
  ) u_power_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (exp),
    .wdata (power),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rest  <= value;
            power <= VALUE_BITS'(1);
            exp   <= '0;
            base  <= sat_radix(radix);
            state <= ST_ASCEND;
          end
        end
        ST_ASCEND: begin
          if (asc_ok) begin
            power <= prod[VALUE_BITS-1:0];
            exp   <= exp + ADDR_W'(1);
          end else begin
            d     <= 4'd0;
            s     <= top_bit(base);
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (fit) begin
            rest <= rest - trial[VALUE_BITS-1:0];
            d    <= d | (4'd1 << s);
          end
          if (s == 2'd0) begin
            state <= ST_EMIT;
          end else begin
            s <= s - 2'd1;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            if (exp == '0) begin
              state <= ST_IDLE;
            end else begin
              exp   <= ram_raddr;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          power <= ram_rdata;
          d     <= 4'd0;
          s     <= top_bit(base);
          state <= ST_DIGIT;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_EMIT) && emit_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && emit_go) begin
      digit_char <= digit_to_ascii(d);
      last_digit <= (exp == '0);
    end
  end

  // checks
  `I2RD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `I2RD_ASSERT_NOW(a_digit_below_base, clk, rst, state == ST_EMIT, ({1'b0, d} < base))
  `I2RD_ASSERT_NEXT(a_held_output, clk, rst, out_valid && !out_ready,
    out_valid && $stable(digit_char) && $stable(last_digit))

endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2rd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  localparam logic [2:0] ADDR_RADIX  = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } digit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  digit_char;
  logic        last_digit;

  // testbench copy of the radix register
  logic [4:0]  radix_copy = RADIX_RESET;

  logic [31:0] pending_values[$];
  digit_t      expected_digits[$];

  int errors = 0;
  int cycles = 0;
  int idle_pct = 20;
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_gap = 0;

  integer_to_radix_digits dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .digit_char(digit_char), .last_digit(last_digit)
  );

  always #5 clk = ~clk;

  // base after clamping into 2..16
  function automatic logic [4:0] effective_base();
    logic [4:0] b;
    b = radix_copy;
    if (b < RADIX_MIN) b = RADIX_MIN;
    if (b > RADIX_MAX) b = RADIX_MAX;
    return b;
  endfunction

  // digits of one value, most significant first
  function automatic void predict_digits(input logic [31:0] v);
    logic [63:0] rest, pw, d;
    logic [4:0]  b;
    digit_t      w;
    b = effective_base();
    rest = {32'b0, v};
    pw = 64'd1;
    while (pw <= rest / b) pw = pw * b;
    do begin
      d = rest / pw;
      rest = rest - d * pw;
      if (d < DECIMAL_TEN) w.ch = ASCII_ZERO + d[6:0];
      else w.ch = ASCII_UPPER_A + (d[6:0] - {3'b000, DECIMAL_TEN});
      w.last = (pw == 64'd1);
      expected_digits.push_back(w);
      pw = pw / b;
    end while (pw != 64'd0);
  endfunction

  // random value biased toward powers of the base and short numbers
  function automatic logic [31:0] random_value();
    logic [63:0] pw;
    logic [4:0]  b;
    logic [31:0] v;
    int          k;
    b = effective_base();
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = $urandom_range(0, 300);
      2, 3: begin
        pw = 64'd1;
        k = $urandom_range(0, 32);
        repeat (k) if (pw * b <= 64'hFFFF_FFFF) pw = pw * b;
        v = pw[31:0] + $urandom_range(0, 2) - 1;
      end
      4: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
    endcase
    return v;
  endfunction

  // one apb transfer: setup cycle, access cycle
  task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] wd,
                            output logic [31:0] rd);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= wr;
    paddr <= a;
    pwdata <= wd;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (wr && a == ADDR_RADIX) radix_copy = wd[4:0];
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // write radix and read it back
  task automatic set_radix(input logic [31:0] w);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_RADIX, w, rd);
    apb_access(1'b0, ADDR_RADIX, 32'h0, rd);
    if (rd !== {27'b0, radix_copy}) begin
      $error("radix readback: expected %0d, got %0d", radix_copy, rd);
      errors++;
    end
  endtask

  // wait until the block is empty, then let it settle
  task automatic drain();
    do @(posedge clk);
    while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_random(input logic [31:0] w, input int n, input int pct);
    set_radix(w);
    idle_pct = pct;
    repeat (n) pending_values.push_back(random_value());
    drain();
  endtask

  // input driver
  always @(posedge clk) begin : drive
    logic        nv;
    logic [31:0] nval;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      nv = in_valid;
      nval = value;
      if (in_valid && in_ready) begin
        predict_digits(value);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_values.size() > 0) begin
          if (!calm && $urandom_range(0, 99) < idle_pct) begin
            send_gap = $urandom_range(1, 3) - 1;
          end else begin
            nv = 1'b1;
            nval = pending_values.pop_front();
          end
        end
      end
      in_valid <= nv;
      value <= nval;
    end
  end

  // output monitor and checker
  always @(posedge clk) begin : collect
    digit_t want;
    logic   rdy;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected word: digit_char %0d last_digit %0d", digit_char, last_digit);
          errors++;
        end else begin
          want = expected_digits.pop_front();
          if (digit_char !== want.ch) begin
            $error("digit_char: expected %0d, got %0d", want.ch, digit_char);
            errors++;
          end
          if (last_digit !== want.last) begin
            $error("last_digit: expected %0d, got %0d", want.last, last_digit);
            errors++;
          end
        end
      end
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD - 1;
        rdy = 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rdy = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        recv_gap = $urandom_range(1, 3) - 1;
        rdy = 1'b0;
      end
      out_ready <= rdy;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus sequence
  initial begin : stimulus
    logic [31:0] rd;
    rst <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset base, decimal edges
    idle_pct = 20;
    pending_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd1000000000,
                       32'd3999999999, 32'hFFFF_FFFF};
    drain();

    // binary edges
    set_radix(32'd2);
    pending_values = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'hFFFF_FFFF};
    drain();

    // hex edges, letters included
    set_radix(32'd16);
    pending_values = '{32'd15, 32'd16, 32'd255, 32'd256, 32'hFFFF_FFFF, 32'hABCD_EF01};
    drain();

    // write to an unused address leaves radix alone
    apb_access(1'b1, ADDR_UNUSED, 32'd5, rd);
    apb_access(1'b0, ADDR_RADIX, 32'h0, rd);
    if (rd !== {27'b0, radix_copy}) begin
      $error("radix readback: expected %0d, got %0d", radix_copy, rd);
      errors++;
    end
    pending_values = '{32'd4096, 32'h0FFF_FFFF};
    drain();

    // long output stall in base 2 so the block backs up
    hold_requests++;
    run_random(32'd2, 18, 25);
    run_random(32'd0, 16, 10);
    run_random(32'd31, 16, 40);
    run_random(32'd17, 16, 0);
    run_random(32'd1, 16, 25);
    run_random(32'hFFFF_FFE3, 16, 25);
    run_random(32'd36, 16, 10);
    run_random(32'd8, 16, 40);
    run_random(32'd9, 16, 25);
    run_random(32'd5, 16, 0);
    run_random($urandom, 16, 25);
    run_random(32'd16, 16, 25);

    // closing stretch with no idling
    calm = 1'b1;
    run_random(32'd10, 16, 0);
    repeat (100) @(posedge clk);

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
